@@ hw/rtl/atanla_pkg.sv @@
package atanla_pkg;

  localparam int X_W       = 32;
  localparam int T_W       = 40;
  localparam int SUM_W     = 42;
  localparam int FIRST_SH  = 56;
  localparam int DVD_W     = FIRST_SH + 1;
  localparam int REM_W     = 32;
  localparam int THR_W     = 30;
  localparam int ANGLE_W   = 32;
  localparam int TERMS_W   = 7;
  localparam int RND_SH    = 12;
  localparam int MAX_TERMS = 64;
  localparam int N_W       = $clog2(MAX_TERMS + 1);
  localparam int K_W       = $clog2(2 * MAX_TERMS + 4);
  localparam int CNT_W     = $clog2(T_W + 1);

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1074);
  localparam logic [X_W-1:0]     ONE_Q16     = X_W'(65536);
  localparam logic [ANGLE_W-1:0] HALF_PI_Q28 = ANGLE_W'(421657428);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FIRST,
    S_RATIO,
    S_RATIO_DIV,
    S_SCALE1,
    S_SCALE2,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DOP_FIRST,
    DOP_RATIO,
    DOP_SCALE
  } div_op_t;

  typedef struct packed {
    logic    load_x;
    logic    div_start;
    div_op_t div_op;
    logic    term_first;
    logic    term_add;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dom;
    logic below;
    logic n_max;
  } sts_t;

endpackage

@@ hw/rtl/atanla_div.sv @@
module atanla_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [atanla_pkg::DVD_W-1:0] dividend,
  input  logic [atanla_pkg::REM_W-1:0] divisor,
  output logic                         busy,
  output logic [atanla_pkg::T_W-1:0]   quo
);
  import atanla_pkg::*;

  logic             run_r, run_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [T_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0] dsr_r, dsr_nxt;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // The quotient is known to fit in T_W bits, so the upper dividend bits seed the remainder.
  always_comb begin
    trial   = {rem_r, dvd_r[T_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(T_W);
      rem_nxt = REM_W'(dividend[DVD_W-1:T_W]);
      dvd_nxt = dividend[T_W-1:0];
      dsr_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd_nxt = {dvd_r[T_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      run_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = run_r;
  assign quo  = dvd_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !run_r)
    else $error("Divider started while busy.");
  a_runs: assert property (@(posedge clk) disable iff (!rst_n) start |=> run_r && cnt_r == CNT_W'(T_W))
    else $error("Divider did not begin after start.");

endmodule

@@ hw/rtl/atanla_dp.sv @@
module atanla_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [atanla_pkg::THR_W-1:0]   cfg_wdata,
  input  logic [atanla_pkg::X_W-1:0]     in_x,
  input  atanla_pkg::cmd_t               cmd,
  output atanla_pkg::sts_t               sts,
  output logic [atanla_pkg::ANGLE_W-1:0] out_angle,
  output logic [atanla_pkg::TERMS_W-1:0] out_terms,
  output logic                           out_dom,
  output logic                           out_capped
);
  import atanla_pkg::*;

  logic [THR_W-1:0]   thr_r;
  logic [X_W-1:0]     ax_r;
  logic               xneg_r;
  logic [T_W-1:0]     t_r;
  logic               tneg_r;
  logic [SUM_W-1:0]   sum_r;
  logic [N_W-1:0]     n_r;
  logic               capped_r;
  logic [ANGLE_W-1:0] angle_r;
  logic [TERMS_W-1:0] terms_r;
  logic               dom_r;
  logic               ocap_r;

  logic [DVD_W-1:0]     dividend;
  logic [REM_W-1:0]     divisor;
  logic                 busy;
  logic [T_W-1:0]       quo;
  logic [K_W-1:0]       num_k;
  logic [K_W-1:0]       den_k;
  logic [T_W+K_W-1:0]   prod;
  logic [T_W-1:0]       limit;
  logic                 below;
  logic                 n_max;
  logic                 dom;
  logic                 term_neg;
  logic [SUM_W-1:0]     qx;
  logic [SUM_W-1:0]     sum_nxt;
  logic [SUM_W-1:0]     rs;
  logic signed [SUM_W-1:0] shifted;
  logic [ANGLE_W-1:0]   half_off;
  logic [ANGLE_W-1:0]   angle;

  atanla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (busy),
    .quo      (quo)
  );

  always_comb begin
    num_k = (K_W'(n_r) << 1) + K_W'(1);
    den_k = num_k + K_W'(2);
    prod  = t_r * num_k;
    case (cmd.div_op)
      DOP_FIRST: begin
        dividend = (DVD_W'(1) << FIRST_SH) + DVD_W'(ax_r >> 1);
        divisor  = ax_r;
      end
      DOP_RATIO: begin
        dividend = DVD_W'(prod);
        divisor  = REM_W'(den_k);
      end
      DOP_SCALE: begin
        dividend = DVD_W'({quo, 16'b0});
        divisor  = ax_r;
      end
      default: begin
        dividend = '0;
        divisor  = ax_r;
      end
    endcase
    limit    = {thr_r, 10'b0};
    below    = quo < limit;
    n_max    = n_r >= N_W'(MAX_TERMS);
    dom      = ax_r <= ONE_Q16;
    term_neg = cmd.term_first ? !xneg_r : !tneg_r;
    qx       = SUM_W'(quo);
    sum_nxt  = (cmd.term_first ? '0 : sum_r) + (term_neg ? (~qx + SUM_W'(1)) : qx);
    rs       = sum_r + SUM_W'(1 << (RND_SH - 1));
    shifted  = $signed(rs) >>> RND_SH;
    half_off = xneg_r ? (~HALF_PI_Q28 + ANGLE_W'(1)) : HALF_PI_Q28;
    angle    = ANGLE_W'(shifted) + half_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
    if (cmd.load_x) begin
      xneg_r <= in_x[X_W-1];
      ax_r   <= in_x[X_W-1] ? (~in_x + X_W'(1)) : in_x;
    end
    if (cmd.div_start && cmd.div_op == DOP_RATIO) begin
      n_r <= n_r + N_W'(1);
    end
    if (cmd.term_first) begin
      n_r      <= '0;
      capped_r <= 1'b0;
    end
    if (cmd.term_first || cmd.term_add) begin
      t_r    <= quo;
      tneg_r <= term_neg;
      sum_r  <= sum_nxt;
    end
    if (cmd.term_add) begin
      capped_r <= !below && n_max;
    end
    if (cmd.out_load) begin
      angle_r <= dom ? '0 : angle;
      terms_r <= dom ? '0 : TERMS_W'(n_r);
      dom_r   <= dom;
      ocap_r  <= dom ? 1'b0 : capped_r;
    end
  end

  assign sts.div_busy = busy;
  assign sts.dom      = dom;
  assign sts.below    = below;
  assign sts.n_max    = n_max;
  assign out_angle    = angle_r;
  assign out_terms    = terms_r;
  assign out_dom      = dom_r;
  assign out_capped   = ocap_r;

  a_term_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term_add |-> quo <= t_r)
    else $error("Series term grew from one step to the next.");
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term_add |-> n_r <= N_W'(MAX_TERMS))
    else $error("Term count passed its limit.");

endmodule

@@ hw/rtl/atanla_ctrl.sv @@
module atanla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  atanla_pkg::sts_t sts,
  output atanla_pkg::cmd_t cmd
);
  import atanla_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK:     state_nxt = sts.dom ? S_OUT : S_FIRST;
      S_FIRST:     if (!sts.div_busy) state_nxt = S_RATIO;
      S_RATIO:     state_nxt = S_RATIO_DIV;
      S_RATIO_DIV: if (!sts.div_busy) state_nxt = S_SCALE1;
      S_SCALE1:    if (!sts.div_busy) state_nxt = S_SCALE2;
      S_SCALE2: begin
        if (!sts.div_busy) begin
          state_nxt = (sts.below || sts.n_max) ? S_OUT : S_RATIO;
        end
      end
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.load_x = in_tvalid;
      end
      S_CHECK: begin
        cmd.div_start = !sts.dom;
        cmd.div_op    = DOP_FIRST;
      end
      S_FIRST: begin
        cmd.term_first = !sts.div_busy;
      end
      S_RATIO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_RATIO;
      end
      S_RATIO_DIV, S_SCALE1: begin
        cmd.div_start = !sts.div_busy;
        cmd.div_op    = DOP_SCALE;
      end
      S_SCALE2: begin
        cmd.term_add = !sts.div_busy;
      end
      S_OUT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_wait_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> !sts.div_busy)
    else $error("Result stage reached with the divider still running.");
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CHECK)
    else $error("Accepted beat was not taken into the check step.");

endmodule

@@ hw/rtl/arctan_series_large_argument.sv @@
// Arctangent for arguments of magnitude above one, summed as the series
// sign(x)*pi/2 - 1/x + 1/(3x^3) - ... in Q0.40 and returned in Q3.28 with the
// number of terms added after the first and domain and cap flags. All division
// goes through one restoring divider that makes one quotient bit per cycle.
// An item takes one division for the first term and three per later term,
// and at most 64 terms are added after the first; an argument of magnitude
// one or less needs no division. The next beat is accepted once the result
// is handed to the output register.
module arctan_series_large_argument (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata,   // stop_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] x
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] angle, [38:32] terms, [39] zero
  output logic [1:0]  out_tuser    // [0] domain_error, [1] capped
);
  import atanla_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [ANGLE_W-1:0] angle;
  logic [TERMS_W-1:0] terms;
  logic               dom;
  logic               capped;

  atanla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  atanla_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_x       (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_angle  (angle),
    .out_terms  (terms),
    .out_dom    (dom),
    .out_capped (capped)
  );

  assign out_tdata = {1'b0, terms, angle};
  assign out_tuser = {capped, dom};

endmodule
